### rtl/core/tad_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the touch anomaly detector.
// No dependencies; imported by tad_window and touch_anomaly_detector.
package tad_pkg;

  // Finger counts above this are clamped to it.
  localparam logic [3:0] MAX_FINGERS = 4'd10;

  localparam int unsigned USEC_PER_MS = 1000;
  localparam logic signed [21:0] USEC_PER_SEC = 22'sd1000000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_JITTER_LIMIT   = 3'd0,
    CFG_PRESS_WINDOW   = 3'd1,
    CFG_RELEASE_WINDOW = 3'd2,
    CFG_REMOVAL_WINDOW = 3'd3,
    CFG_REPORT_LIMIT   = 3'd4,
    CFG_PRESSURE_LOW   = 3'd5,
    CFG_PRESSURE_HIGH  = 3'd6,
    CFG_FINGER_JUMP    = 3'd7
  } cfg_idx_e;

  // Windows are held already scaled to microseconds (at most 1,023,000).
  typedef struct packed {
    logic [15:0] jitter_limit;
    logic [19:0] press_win_us;
    logic [19:0] release_win_us;
    logic [19:0] removal_win_us;
    logic [15:0] report_limit;
    logic [15:0] pressure_low;
    logic [15:0] pressure_high;
    logic [4:0]  finger_jump;
  } cfg_t;

  // One timestamp as carried by a touch report.
  typedef struct packed {
    logic [31:0] sec;
    logic [19:0] usec;
  } stamp_t;

  // Scales a millisecond window to microseconds.
  function automatic logic [19:0] ms_to_us(input logic [9:0] ms);
    logic [19:0] prod;
    prod = 20'(ms) * 20'(USEC_PER_MS);
    return prod;
  endfunction

endpackage

### rtl/core/tad_window.sv
`timescale 1ns / 1ps
// Time window test between a current and an earlier timestamp.
// Depends on tad_pkg for stamp_t and USEC_PER_SEC.
module tad_window import tad_pkg::*; (
  input  stamp_t      now_i,
  input  stamp_t      then_i,
  input  logic [19:0] limit_us_i,
  output logic        hit_o
);

  logic               same_sec;
  logic               next_sec;
  logic signed [21:0] now_us;
  logic signed [21:0] then_us;
  logic signed [21:0] lim_us;
  logic signed [21:0] gap_same;
  logic signed [21:0] gap_next;

  assign same_sec = (now_i.sec == then_i.sec);
  assign next_sec = (now_i.sec == then_i.sec + 32'd1);

  assign now_us  = $signed({2'b00, now_i.usec});
  assign then_us = $signed({2'b00, then_i.usec});
  assign lim_us  = $signed({2'b00, limit_us_i});

  // Within the same second an earlier microsecond value wraps by a full second.
  // Out-of-range microseconds may make the gap negative, which still passes.
  assign gap_next = now_us + USEC_PER_SEC - then_us;
  assign gap_same = (now_i.usec >= then_i.usec) ? (now_us - then_us) : gap_next;

  always_comb begin
    if (same_sec) begin
      hit_o = (gap_same <= lim_us);
    end else if (next_sec) begin
      hit_o = (gap_next <= lim_us);
    end else begin
      hit_o = 1'b0;
    end
  end

endmodule

### rtl/core/touch_anomaly_detector.sv
`timescale 1ns / 1ps
// Top level of the touch anomaly detector: input register, evaluation, result register.
// Depends on tad_pkg and tad_window.

// The detector takes one touch report word per clock cycle and returns one
// result word for each, in order. A report enters an input register, is
// evaluated combinationally against the stored touch history with compares
// and small adds, and its result is written to an output register together
// with the updated history, so the throughput is one word per cycle for as
// long as the output side keeps taking results. When the output register
// holds a word that has not been taken, the input register still accepts
// one more word and the detector then stalls. The anomaly counter saturates
// at 65535; whenever it exceeds report_limit after a report's increments,
// it is cleared and report_o is raised with a count of zero. Configuration
// writes take effect on the next evaluated word and are meant to happen
// only while no word is in flight. Millisecond windows are scaled to
// microseconds when they are written.
module touch_anomaly_detector import tad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Touch report input.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  finger_count_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] pressure_i,
  input  logic [31:0] stamp_sec_i,
  input  logic [19:0] stamp_usec_i,
  // Result output.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        report_o,
  output logic [15:0] anomaly_count_o
);

  // Configuration registers.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.jitter_limit   <= 16'd10;
      cfg_q.press_win_us   <= ms_to_us(10'd100);
      cfg_q.release_win_us <= ms_to_us(10'd100);
      cfg_q.removal_win_us <= ms_to_us(10'd100);
      cfg_q.report_limit   <= 16'd10;
      cfg_q.pressure_low   <= 16'd20;
      cfg_q.pressure_high  <= 16'd255;
      cfg_q.finger_jump    <= 5'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_JITTER_LIMIT:   cfg_q.jitter_limit   <= cfg_data_i;
        CFG_PRESS_WINDOW:   cfg_q.press_win_us   <= ms_to_us(cfg_data_i[9:0]);
        CFG_RELEASE_WINDOW: cfg_q.release_win_us <= ms_to_us(cfg_data_i[9:0]);
        CFG_REMOVAL_WINDOW: cfg_q.removal_win_us <= ms_to_us(cfg_data_i[9:0]);
        CFG_REPORT_LIMIT:   cfg_q.report_limit   <= cfg_data_i;
        CFG_PRESSURE_LOW:   cfg_q.pressure_low   <= cfg_data_i;
        CFG_PRESSURE_HIGH:  cfg_q.pressure_high  <= cfg_data_i;
        CFG_FINGER_JUMP:    cfg_q.finger_jump    <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  // Input register. It advances into the evaluation whenever the output
  // register is empty or its word is being taken in the same cycle.
  logic        in_vld_q;
  logic [3:0]  cnt_q;
  logic [15:0] x_q;
  logic [15:0] y_q;
  logic [15:0] z_q;
  stamp_t      now_q;
  logic        adv;
  logic        out_vld_q;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cnt_q      <= finger_count_i;
      x_q        <= pos_x_i;
      y_q        <= pos_y_i;
      z_q        <= pressure_i;
      now_q.sec  <= stamp_sec_i;
      now_q.usec <= stamp_usec_i;
    end
  end

  // Touch history.
  logic [15:0] last_x_q;
  logic [15:0] last_y_q;
  logic [3:0]  last_cnt_q;
  stamp_t      press_q;
  stamp_t      release_q;
  logic [15:0] anomalies_q;

  // Evaluation of the registered report.
  logic [3:0]  cnt;
  logic [15:0] dx;
  logic [15:0] dy;
  logic        same_spot;
  logic        rise;
  logic        fall;
  logic        pp_hit;
  logic        rp_hit;
  logic        rm_hit;
  logic        inc_press;
  logic        inc_tap;
  logic        inc_jump;
  logic        inc_remove;
  logic [1:0]  n_inc;
  logic [16:0] sum;
  logic [15:0] sat;
  logic        report_d;
  logic [15:0] anomalies_d;

  assign cnt = (cnt_q > MAX_FINGERS) ? MAX_FINGERS : cnt_q;

  assign dx = (last_x_q > x_q) ? (last_x_q - x_q) : (x_q - last_x_q);
  assign dy = (last_y_q > y_q) ? (last_y_q - y_q) : (y_q - last_y_q);
  assign same_spot = (dx <= cfg_q.jitter_limit) && (dy <= cfg_q.jitter_limit);

  assign rise = (last_cnt_q < cnt);
  assign fall = (last_cnt_q > cnt);

  tad_window u_press_win (
    .now_i      (now_q),
    .then_i     (press_q),
    .limit_us_i (cfg_q.press_win_us),
    .hit_o      (pp_hit)
  );

  tad_window u_release_win (
    .now_i      (now_q),
    .then_i     (release_q),
    .limit_us_i (cfg_q.release_win_us),
    .hit_o      (rp_hit)
  );

  tad_window u_removal_win (
    .now_i      (now_q),
    .then_i     (press_q),
    .limit_us_i (cfg_q.removal_win_us),
    .hit_o      (rm_hit)
  );

  // Pressure is only checked when at least one finger is down.
  assign inc_press  = (cnt != 4'd0) &&
                      ((z_q > cfg_q.pressure_high) || (z_q < cfg_q.pressure_low));
  // A repeated tap counts once, whether it follows a press or a release.
  assign inc_tap    = rise && same_spot && (((last_cnt_q != 4'd0) && pp_hit) || rp_hit);
  assign inc_jump   = rise && ({1'b0, cnt - last_cnt_q} >= cfg_q.finger_jump);
  assign inc_remove = fall && same_spot && rm_hit;

  // A rise and a fall exclude each other, so at most three increments apply.
  assign n_inc = 2'(inc_press) + 2'(inc_tap) + 2'(inc_jump) + 2'(inc_remove);
  assign sum   = {1'b0, anomalies_q} + 17'(n_inc);
  assign sat   = sum[16] ? 16'hFFFF : sum[15:0];

  assign report_d    = (sat > cfg_q.report_limit);
  assign anomalies_d = report_d ? 16'd0 : sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_cnt_q  <= '0;
      press_q     <= '0;
      release_q   <= '0;
      anomalies_q <= '0;
    end else if (adv) begin
      last_x_q    <= x_q;
      last_y_q    <= y_q;
      last_cnt_q  <= cnt;
      anomalies_q <= anomalies_d;
      if (rise) begin
        press_q <= now_q;
      end
      if (fall) begin
        release_q <= now_q;
      end
    end
  end

  // Output register.
  logic        report_q;
  logic [15:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      report_q <= report_d;
      count_q  <= anomalies_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign report_o        = report_q;
  assign anomaly_count_o = count_q;

  // A raised report always comes with a cleared counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && report_q |-> count_q == 16'd0)
    else $error("report raised with nonzero count");

  // The stored finger count never exceeds the clamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_cnt_q <= MAX_FINGERS)
    else $error("stored finger count above clamp");

  // History only changes when a word moves into the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(anomalies_q) && $stable(last_cnt_q) && $stable(press_q))
    else $error("history changed without an evaluated word");

  // The presented count matches the counter written with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q && count_q == anomalies_q)
    else $error("result out of step with counter");

endmodule
